@@ rtl/substring_occurrence_counter_core_defines.svh @@
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef SUBSTRING_OCCURRENCE_COUNTER_CORE_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SOC_ASSERT_SAME(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error("soc: check failed in same cycle");
`define SOC_ASSERT_NEXT(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("soc: check failed in next cycle");
`else
`define SOC_ASSERT_SAME(label, cause, effect)
`define SOC_ASSERT_NEXT(label, cause, effect)
`endif

`endif

@@ rtl/soc_pkg.sv @@
package soc_pkg;

   localparam int PATTERN_STORE       = 32;
   localparam int MAX_PATTERN_DEFAULT = 32;
   localparam int COUNT_BITS_DEFAULT  = 32;
   localparam int LENGTH_BITS         = 6;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int CSR_DATA_BITS       = 64;
   localparam int RESULT_BITS         = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_WORD_3 = 3'd4;

   typedef struct packed {
      logic                   shift;
      logic                   clear;
      logic [LENGTH_BITS-1:0] length;
   } soc_cell_ctrl_type;

endpackage

@@ rtl/soc_cell.sv @@
module soc_cell #(
   parameter int AGE = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  soc_pkg::soc_cell_ctrl_type ctrl,
   input  logic [7:0]                 byte_in,
   input  logic                       valid_in,
   input  logic [7:0]                 pattern_byte,
   output logic [7:0]                 byte_out,
   output logic                       valid_out,
   output logic                       ok
);
   import soc_pkg::*;

   localparam logic [7:0] AGE_L = 8'(AGE);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;
   logic       valid_ff;
   logic       valid_in_mux;

   always_comb begin
      valid_in_mux = valid_ff;
      byte_in_mux  = byte_ff;
      if (ctrl.clear) begin
         valid_in_mux = 1'b0;
      end else if (ctrl.shift) begin
         valid_in_mux = valid_in;
         byte_in_mux  = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_mux;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   // positions at or beyond the pattern length do not take part
   assign ok        = ({2'b00, ctrl.length} <= AGE_L) ||
                      (valid_ff && (byte_ff == pattern_byte));
   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

@@ rtl/substring_occurrence_counter_core.sv @@
// The count is registered and presented in the cycle after the last-marked byte is accepted.
// Throughput: one text byte per cycle; the window compare across the cell row is parallel.
// Only a last-marked byte waits for the result register; other bytes pass while it is full.
// Synchronous reset clears the pattern registers, window, count and terminator flag.
`include "substring_occurrence_counter_core_defines.svh"
module substring_occurrence_counter_core #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEFAULT,
   parameter int COUNT_BITS  = soc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [soc_pkg::RESULT_BITS-1:0]      rsp_match_count,
   input  logic                                 csr_write_enable,
   input  logic [soc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [soc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import soc_pkg::*;

   localparam int WINDOW = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int LIMIT  = (MAX_PATTERN < PATTERN_STORE) ? MAX_PATTERN : PATTERN_STORE;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // configuration
   logic [LENGTH_BITS-1:0]   pattern_length_ff, pattern_length_in;
   logic [CSR_DATA_BITS-1:0] pattern_word_ff [4];
   logic [CSR_DATA_BITS-1:0] pattern_word_in [4];

   always_comb begin
      pattern_length_in = pattern_length_ff;
      for (int w = 0; w < 4; w++) begin
         pattern_word_in[w] = pattern_word_ff[w];
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_in  = csr_write_data[LENGTH_BITS-1:0];
            CSR_PATTERN_WORD_0: pattern_word_in[0] = csr_write_data;
            CSR_PATTERN_WORD_1: pattern_word_in[1] = csr_write_data;
            CSR_PATTERN_WORD_2: pattern_word_in[2] = csr_write_data;
            CSR_PATTERN_WORD_3: pattern_word_in[3] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         for (int w = 0; w < 4; w++) begin
            pattern_word_ff[w] <= '0;
         end
      end else begin
         pattern_length_ff <= pattern_length_in;
         for (int w = 0; w < 4; w++) begin
            pattern_word_ff[w] <= pattern_word_in[w];
         end
      end
   end

   // effective length and pattern aligned to byte age (age 0 = current byte)
   logic [LENGTH_BITS-1:0]     length_eff;
   logic [LENGTH_BITS-1:0]     gap;
   logic [PATTERN_STORE*8-1:0] pattern_flat;
   logic [PATTERN_STORE*8-1:0] pattern_rev;
   logic [PATTERN_STORE*8-1:0] aligned;

   always_comb begin
      length_eff   = (pattern_length_ff > LENGTH_BITS'(LIMIT)) ? LENGTH_BITS'(LIMIT)
                                                               : pattern_length_ff;
      pattern_flat = {pattern_word_ff[3], pattern_word_ff[2],
                      pattern_word_ff[1], pattern_word_ff[0]};
      for (int i = 0; i < PATTERN_STORE; i++) begin
         pattern_rev[i*8 +: 8] = pattern_flat[(PATTERN_STORE-1-i)*8 +: 8];
      end
      gap     = LENGTH_BITS'(PATTERN_STORE) - length_eff;
      aligned = pattern_rev >> {gap, 3'b000};
   end

   // stream control
   logic                  accept;
   logic                  active;
   logic                  clear;
   logic                  hit;
   logic                  terminator_ff, terminator_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] count_next;
   logic [63:0]           count_wide;
   soc_cell_ctrl_type     cell_ctrl;

   logic [7:0]        cell_byte  [WINDOW];
   logic [WINDOW-1:0] cell_valid;
   logic [WINDOW-1:0] cell_ok;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_count_ff, rsp_count_in;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign accept    = req_valid && req_ready;
   assign active    = accept && !terminator_ff && (req_text_byte != 8'h00);
   assign clear     = accept && req_last_byte;

   assign cell_ctrl.shift  = active;
   assign cell_ctrl.clear  = clear;
   assign cell_ctrl.length = length_eff;

   genvar k;
   generate
      for (k = 0; k < WINDOW; k++) begin : g_cell
         logic [7:0] byte_in_k;
         logic       valid_in_k;
         logic [7:0] pattern_k;
         if (k == 0) begin : g_head
            assign byte_in_k  = req_text_byte;
            assign valid_in_k = 1'b1;
         end else begin : g_link
            assign byte_in_k  = cell_byte[k-1];
            assign valid_in_k = cell_valid[k-1];
         end
         if (k + 1 < PATTERN_STORE) begin : g_cmp
            assign pattern_k = aligned[(k+1)*8 +: 8];
         end else begin : g_nocmp
            assign pattern_k = 8'h00;
         end
         soc_cell #(
            .AGE (k + 1)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (cell_ctrl),
            .byte_in      (byte_in_k),
            .valid_in     (valid_in_k),
            .pattern_byte (pattern_k),
            .byte_out     (cell_byte[k]),
            .valid_out    (cell_valid[k]),
            .ok           (cell_ok[k])
         );
      end
   endgenerate

   always_comb begin
      hit        = (length_eff != '0) && (req_text_byte == aligned[7:0]) && (&cell_ok);
      count_next = (hit && (total_ff != COUNT_MAX)) ? total_ff + COUNT_BITS'(1) : total_ff;
      count_wide = 64'(active ? count_next : total_ff);

      total_in      = total_ff;
      terminator_in = terminator_ff;
      if (clear) begin
         total_in      = '0;
         terminator_in = 1'b0;
      end else if (active) begin
         total_in = count_next;
      end else if (accept && (req_text_byte == 8'h00)) begin
         terminator_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (clear) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_wide[RESULT_BITS-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         terminator_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         total_ff      <= total_in;
         terminator_ff <= terminator_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

   `SOC_ASSERT_NEXT(a_last_gives_result, clear, rsp_valid_ff)
   `SOC_ASSERT_NEXT(a_last_clears_stream, clear,
                    (cell_valid == '0) && !terminator_ff && (total_ff == '0))
   `SOC_ASSERT_NEXT(a_stopped_holds_count, accept && terminator_ff && !req_last_byte,
                    $stable(total_ff))
   `SOC_ASSERT_SAME(a_stopped_no_shift, terminator_ff, !cell_ctrl.shift)

endmodule
